// ===== src/tmvs_pkg.sv =====
// Shared constants, types and control structs of the tolerance-match vector set.
`default_nettype none
package tmvs_pkg;

    // Vector length and table size
    localparam int JOINTS      = 6;
    localparam int TABLE_DEPTH = 64;

    // Field widths fixed by the interface
    localparam int ANGLE_W     = 16;
    localparam int TOL_W       = 15;
    localparam int MATCH_W     = 6;
    localparam int COUNT_OUT_W = 7;

    // Tolerance register file
    localparam int NUM_TOL   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int TOL_RESET = 164;

    // Derived widths
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W  = $clog2(JOINTS + 1);
    localparam int QIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef t_angle [JOINTS-1:0]       t_vec;
    typedef logic [TOL_W-1:0]          t_tol;
    typedef t_tol [JOINTS-1:0]         t_tol_vec;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_token;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic occupied;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== src/tmvs_cell.sv =====
// One table cell: holds a stored vector and compares it against the passing search token.
`default_nettype none
module tmvs_cell
    import tmvs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_cell_index,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_vec             i_query,
    input  wire t_tol_vec         i_tol,
    input  wire t_token           i_tok,
    output t_token                o_tok
);

    t_vec   r_entry;
    t_token r_tok;
    t_token n_tok;
    logic   w_hit;

    // Check every joint of the stored vector against its tolerance
    always_comb begin
        logic signed [ANGLE_W:0] v_diff;
        logic        [ANGLE_W:0] v_abs;
        w_hit = 1'b1;
        for (int j = 0; j < JOINTS; j++) begin
            v_diff = {r_entry[j][ANGLE_W-1], r_entry[j]} - {i_query[j][ANGLE_W-1], i_query[j]};
            v_abs  = v_diff[ANGLE_W] ? (~v_diff + 1'b1) : v_diff;
            if (!(v_abs < {{(ANGLE_W + 1 - TOL_W){1'b0}}, i_tol[j]})) begin
                w_hit = 1'b0;
            end
        end
    end

    // Claim the token for this cell when it is the first occupied match
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.found && i_ctl.occupied && w_hit) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_cell_index;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Store a new vector
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_entry <= i_query;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ===== src/tolerance_match_vector_set.sv =====
// Top level: vector collector, search sequencer and the row of table cells.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_action, i_joint_angle, i_last_joint
//  out     | output    | o_out_valid / i_out_ready | o_found, o_match_index, o_added,
//          |           |                           | o_table_full, o_length_error,
//          |           |                           | o_entry_count
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// Angles that do not end a vector are taken without a stall. A last word with a correct
// length starts a token down the row of TABLE_DEPTH cells, one cell per cycle, and the
// result is captured as the token leaves the last cell; a wrong length goes straight to the
// commit step. The input stays stalled from the last word until its result is loaded
// into the output register; a waiting result holds the block in the commit step.
// Reset is synchronous and active low; it empties the table and the collector.
`default_nettype none
module tolerance_match_vector_set
    import tmvs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [TOL_W-1:0]       i_cfg_data,
    // input words
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_action,
    input  wire logic signed [ANGLE_W-1:0] i_joint_angle,
    input  wire logic                   i_last_joint,
    // result words
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_found,
    output logic [MATCH_W-1:0]          o_match_index,
    output logic                        o_added,
    output logic                        o_table_full,
    output logic                        o_length_error,
    output logic [COUNT_OUT_W-1:0]      o_entry_count
);

    typedef enum logic [1:0] {
        S_COLLECT,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state           r_state;
    t_tol             r_tol [NUM_TOL];
    t_vec             r_query;
    logic [POS_W-1:0] r_pos;
    logic             r_over;
    logic             r_action;
    logic             r_lerr;
    logic             r_start;
    logic             r_res_found;
    logic [IDX_W-1:0] r_res_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;

    logic [POS_W-1:0] n_pos;
    logic             n_over;
    logic             n_lerr;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_commit;
    logic             w_room;
    logic             w_add;
    logic             w_full;

    t_tol_vec  w_tol;
    t_token    w_tok [TABLE_DEPTH+1];
    t_cell_ctl w_ctl [TABLE_DEPTH];

    // Tolerance registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TOL; k++) begin
                r_tol[k] <= TOL_W'(TOL_RESET);
            end
        end else if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(NUM_TOL))) begin
            r_tol[i_cfg_index] <= i_cfg_data;
        end
    end

    for (genvar j = 0; j < JOINTS; j++) begin : g_tol
        assign w_tol[j] = r_tol[j];
    end

    // Handshakes and commit decision
    assign o_in_ready = (r_state == S_COLLECT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    assign w_room     = (r_count < CNT_W'(TABLE_DEPTH));
    assign w_add      = r_action && !r_lerr && !r_res_found && w_room;
    assign w_full     = r_action && !r_lerr && !r_res_found && !w_room;
    assign n_count    = r_count + CNT_W'(w_add);

    // Collector position after the current word
    always_comb begin
        n_pos  = r_pos;
        n_over = r_over;
        if (r_pos < POS_W'(JOINTS)) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_over = 1'b1;
        end
        n_lerr = n_over || (n_pos != POS_W'(JOINTS));
    end

    // Sequencer: collect, search, commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_pos       <= '0;
            r_over      <= 1'b0;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // launch a search on a last word of correct length
            r_start <= w_accept && i_last_joint && !n_lerr;
            // load a result word on commit, drop it once taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_COLLECT: begin
                    if (w_accept) begin
                        if (r_pos < POS_W'(JOINTS)) begin
                            r_query[r_pos[QIDX_W-1:0]] <= i_joint_angle;
                        end
                        if (i_last_joint) begin
                            r_pos       <= '0;
                            r_over      <= 1'b0;
                            r_action    <= i_action;
                            r_lerr      <= n_lerr;
                            r_res_found <= 1'b0;
                            r_res_idx   <= '0;
                            if (n_lerr) begin
                                r_state <= S_COMMIT;
                            end else begin
                                r_state <= S_SEARCH;
                            end
                        end else begin
                            r_pos  <= n_pos;
                            r_over <= n_over;
                        end
                    end
                end
                S_SEARCH: begin
                    // capture the token as it leaves the last cell
                    if (w_tok[TABLE_DEPTH].valid) begin
                        r_res_found <= w_tok[TABLE_DEPTH].found;
                        r_res_idx   <= w_tok[TABLE_DEPTH].found ?
                                       w_tok[TABLE_DEPTH].idx : '0;
                        r_state     <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        r_count        <= n_count;
                        o_found        <= r_res_found;
                        o_match_index  <= MATCH_W'(r_res_idx);
                        o_added        <= w_add;
                        o_table_full   <= w_full;
                        o_length_error <= r_lerr;
                        o_entry_count  <= COUNT_OUT_W'(n_count);
                        r_state        <= S_COLLECT;
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // Inject a fresh token at the head of the row
    assign w_tok[0] = '{valid: r_start, found: 1'b0, idx: '0};

    // Row of table cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign w_ctl[k].wr_en    = w_commit && w_add && (r_count == CNT_W'(k));
        assign w_ctl[k].occupied = (CNT_W'(k) < r_count);

        tmvs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_index (IDX_W'(k)),
            .i_ctl        (w_ctl[k]),
            .i_query      (r_query),
            .i_tol        (w_tol),
            .i_tok        (w_tok[k]),
            .o_tok        (w_tok[k+1])
        );
    end

    // A token leaves the row only while a search is running
    a_tok_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_DEPTH].valid |-> (r_state == S_SEARCH))
        else $error("search token left the row outside a search");

    // Add and refusal are exclusive
    a_add_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_added && o_table_full))
        else $error("result flags both added and table full");

    // A length error carries no match, add or table-full flag
    a_lerr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_error) |-> (!o_found && !o_added && !o_table_full))
        else $error("length error result carries match or add flags");

    // The table never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Committing a word leaves the input open again
    a_commit_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_in_ready && o_out_valid))
        else $error("commit did not reopen the input");

endmodule
`default_nettype wire
